>>> design/segx_pkg.sv
package segx_pkg;

  localparam int CoordW     = 32;
  localparam int DiffW      = CoordW + 1;
  localparam int ProdW      = 64;
  localparam int WideW      = 68;
  localparam int TW         = 25;
  localparam int LimitW     = 16;
  localparam int MarginW    = 24;
  localparam int SmallW     = 9;
  localparam int SqW        = 2 * SmallW;
  localparam int PlaceW     = DiffW + TW + 1;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 24;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);
  localparam int DivSteps   = TW;
  localparam int NumProd    = 6;

  localparam logic [TW-1:0] OneQ24 = TW'(1) << (TW - 1);
  localparam logic [PlaceW-1:0] HalfQ24 = PlaceW'(1) << (TW - 2);

  localparam logic [CfgIdxW-1:0] CfgZeroLength = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgMargin     = CfgIdxW'(1);

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_DEGEN    = 2'd1,
    ST_PARALLEL = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_e;

  typedef struct packed {
    status_e                  status;
    logic signed [WideW-1:0]  den;
    logic signed [WideW-1:0]  n0;
    logic signed [WideW-1:0]  n1;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [DiffW-1:0]  ux;
    logic signed [DiffW-1:0]  uy;
  } item_t;

  typedef struct packed {
    status_e                  status;
    logic [WideW-1:0]         d;
    logic [WideW-1:0]         r0;
    logic [WideW-1:0]         r1;
    logic [TW-1:0]            q0;
    logic [TW-1:0]            q1;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [DiffW-1:0]  ux;
    logic signed [DiffW-1:0]  uy;
  } div_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic [WideW-1:0] r;
    logic [TW-1:0]    q;
  } step_t;

  function automatic logic [DiffW-1:0] abs_mag(input logic signed [DiffW-1:0] x);
    abs_mag = x[DiffW-1] ? DiffW'(-x) : DiffW'(x);
  endfunction

  function automatic logic signed [WideW-1:0] signed_term(input logic [ProdW-1:0] mag,
                                                          input logic neg);
    logic signed [WideW-1:0] ext;
    ext = $signed({{(WideW - ProdW){1'b0}}, mag});
    signed_term = neg ? -ext : ext;
  endfunction

  function automatic step_t div_step(input logic [WideW-1:0] r, input logic [WideW-1:0] d,
                                     input logic [TW-1:0] q, input logic first);
    logic [WideW-1:0] r2;
    logic             ge;
    step_t            res;
    r2 = first ? r : {r[WideW-2:0], 1'b0};
    ge = (r2 >= d);
    res.r = ge ? (r2 - d) : r2;
    res.q = {q[TW-2:0], ge};
    div_step = res;
  endfunction

endpackage

>>> design/segment_intersection_core.sv
// Strict crossing test for pairs of 2D segments in Q24.8, one request accepted per clock while in_stall_o is low.
// A four-stage front end forms the differences, cross products and degenerate test and
// feeds a four-entry queue; the back end runs two 25-stage restoring dividers in lockstep
// (one quotient bit per stage), then a margin check with the placement multiply and a
// final add into the output register. Throughput is one request per cycle when nothing
// stalls, set by the per-stage divider pipeline; the queue lets the front keep accepting
// requests while the result side is stalled, until the queue fills.
module segment_intersection_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [segx_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [segx_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            first_start_x_i,
  input  logic signed [31:0]            first_start_y_i,
  input  logic signed [31:0]            first_end_x_i,
  input  logic signed [31:0]            first_end_y_i,
  input  logic signed [31:0]            second_start_x_i,
  input  logic signed [31:0]            second_start_y_i,
  input  logic signed [31:0]            second_end_x_i,
  input  logic signed [31:0]            second_end_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [24:0]                   t_first_o,
  output logic [24:0]                   t_second_o,
  output logic signed [31:0]            cross_x_o,
  output logic signed [31:0]            cross_y_o
);
  import segx_pkg::*;

  logic [LimitW-1:0]  zlimit_q;
  logic [MarginW-1:0] margin_q;
  logic               push, pop;
  item_t              item, head;
  qstat_t             qstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zlimit_q <= LimitW'(1);
      margin_q <= MarginW'(17);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgZeroLength: zlimit_q <= cfg_data_i[LimitW-1:0];
        CfgMargin:     margin_q <= cfg_data_i[MarginW-1:0];
        default: begin
        end
      endcase
    end
  end

  segx_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .first_start_x_i     (first_start_x_i),
    .first_start_y_i     (first_start_y_i),
    .first_end_x_i       (first_end_x_i),
    .first_end_y_i       (first_end_y_i),
    .second_start_x_i    (second_start_x_i),
    .second_start_y_i    (second_start_y_i),
    .second_end_x_i      (second_end_x_i),
    .second_end_y_i      (second_end_y_i),
    .zero_length_limit_i (zlimit_q),
    .qstat_i             (qstat),
    .push_o              (push),
    .item_o              (item)
  );

  segx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  segx_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (head),
    .qstat_i           (qstat),
    .pop_o             (pop),
    .position_margin_i (margin_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .t_first_o         (t_first_o),
    .t_second_o        (t_second_o),
    .cross_x_o         (cross_x_o),
    .cross_y_o         (cross_y_o)
  );

endmodule

>>> design/segx_front.sv
module segx_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            first_start_x_i,
  input  logic signed [31:0]            first_start_y_i,
  input  logic signed [31:0]            first_end_x_i,
  input  logic signed [31:0]            first_end_y_i,
  input  logic signed [31:0]            second_start_x_i,
  input  logic signed [31:0]            second_start_y_i,
  input  logic signed [31:0]            second_end_x_i,
  input  logic signed [31:0]            second_end_y_i,
  input  logic [segx_pkg::LimitW-1:0]   zero_length_limit_i,
  input  segx_pkg::qstat_t              qstat_i,
  output logic                          push_o,
  output segx_pkg::item_t               item_o
);
  import segx_pkg::*;

  logic                     fe;
  logic                     s1_v_q, s2_v_q, s3_v_q, s4_v_q;

  logic signed [DiffW-1:0]  ux_q, uy_q, vx_q, vy_q, ey_q, ex_q;
  logic signed [CoordW-1:0] ax1_q, ay1_q, ax2_q, ay2_q, ax3_q, ay3_q;
  logic signed [DiffW-1:0]  ux2_q, uy2_q, ux3_q, uy3_q;

  logic signed [DiffW-1:0]  opa [NumProd];
  logic signed [DiffW-1:0]  opb [NumProd];
  logic [ProdW-1:0]         p_q [NumProd];
  logic                     pn_q [NumProd];
  logic                     degen2_q, degen3_q;
  logic                     short_u, short_v;
  logic signed [WideW-1:0]  den3_q, n03_q, n13_q;
  item_t                    s4_q;
  item_t                    s4_d;

  function automatic logic is_short(input logic signed [DiffW-1:0] x,
                                    input logic signed [DiffW-1:0] y,
                                    input logic [LimitW-1:0] lim);
    logic signed [SqW:0] sx, sy, px, py;
    logic [SqW:0]        sq;
    logic                in_range;
    sx = (SqW + 1)'(x);
    sy = (SqW + 1)'(y);
    in_range = (x > -DiffW'(256)) && (x < DiffW'(256)) &&
               (y > -DiffW'(256)) && (y < DiffW'(256));
    px = sx * sx;
    py = sy * sy;
    sq = $unsigned(px) + $unsigned(py);
    is_short = in_range && (sq < (SqW + 1)'(lim));
  endfunction

  assign fe         = !(s4_v_q && qstat_i.full);
  assign in_stall_o = !fe;
  assign push_o     = s4_v_q && !qstat_i.full;
  assign item_o     = s4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (fe) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_comb begin
    opa[0] = uy_q; opb[0] = vx_q;
    opa[1] = ux_q; opb[1] = vy_q;
    opa[2] = vx_q; opb[2] = ey_q;
    opa[3] = vy_q; opb[3] = ex_q;
    opa[4] = ux_q; opb[4] = ey_q;
    opa[5] = uy_q; opb[5] = ex_q;
    short_u = is_short(ux_q, uy_q, zero_length_limit_i);
    short_v = is_short(vx_q, vy_q, zero_length_limit_i);
  end

  always_ff @(posedge clk_i) begin
    if (fe) begin
      ux_q  <= DiffW'(first_end_x_i) - DiffW'(first_start_x_i);
      uy_q  <= DiffW'(first_end_y_i) - DiffW'(first_start_y_i);
      vx_q  <= DiffW'(second_end_x_i) - DiffW'(second_start_x_i);
      vy_q  <= DiffW'(second_end_y_i) - DiffW'(second_start_y_i);
      ey_q  <= DiffW'(second_start_y_i) - DiffW'(first_start_y_i);
      ex_q  <= DiffW'(first_start_x_i) - DiffW'(second_start_x_i);
      ax1_q <= first_start_x_i;
      ay1_q <= first_start_y_i;

      for (int i = 0; i < NumProd; i++) begin
        p_q[i]  <= ProdW'(abs_mag(opa[i]) * abs_mag(opb[i]));
        pn_q[i] <= opa[i][DiffW-1] ^ opb[i][DiffW-1];
      end
      degen2_q <= short_u || short_v;
      ax2_q    <= ax1_q;
      ay2_q    <= ay1_q;
      ux2_q    <= ux_q;
      uy2_q    <= uy_q;

      den3_q   <= signed_term(p_q[0], pn_q[0]) - signed_term(p_q[1], pn_q[1]);
      n03_q    <= signed_term(p_q[2], pn_q[2]) + signed_term(p_q[3], pn_q[3]);
      n13_q    <= signed_term(p_q[4], pn_q[4]) + signed_term(p_q[5], pn_q[5]);
      degen3_q <= degen2_q;
      ax3_q    <= ax2_q;
      ay3_q    <= ay2_q;
      ux3_q    <= ux2_q;
      uy3_q    <= uy2_q;

      s4_q <= s4_d;
    end
  end

  always_comb begin
    s4_d.den = den3_q[WideW-1] ? -den3_q : den3_q;
    s4_d.n0  = den3_q[WideW-1] ? -n03_q : n03_q;
    s4_d.n1  = den3_q[WideW-1] ? -n13_q : n13_q;
    if (degen3_q) begin
      s4_d.status = ST_DEGEN;
    end else if (den3_q == '0) begin
      s4_d.status = ST_PARALLEL;
    end else begin
      s4_d.status = ST_HIT;
    end
    s4_d.ax = ax3_q;
    s4_d.ay = ay3_q;
    s4_d.ux = ux3_q;
    s4_d.uy = uy3_q;
  end

endmodule

>>> design/segx_queue.sv
module segx_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  segx_pkg::item_t  item_i,
  input  logic             pop_i,
  output segx_pkg::item_t  head_o,
  output segx_pkg::qstat_t qstat_o
);
  import segx_pkg::*;

  item_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueueCntW-1:0] cnt_q;

  assign qstat_o.full  = (cnt_q == QueueCntW'(QueueDepth));
  assign qstat_o.empty = (cnt_q == '0);
  assign head_o        = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QueuePtrW'(1);
      end
      cnt_q <= cnt_q + QueueCntW'(push_i) - QueueCntW'(pop_i);
    end
  end

endmodule

>>> design/segx_back.sv
module segx_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  segx_pkg::item_t              head_i,
  input  segx_pkg::qstat_t             qstat_i,
  output logic                         pop_o,
  input  logic [segx_pkg::MarginW-1:0] position_margin_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [24:0]                  t_first_o,
  output logic [24:0]                  t_second_o,
  output logic signed [31:0]           cross_x_o,
  output logic signed [31:0]           cross_y_o
);
  import segx_pkg::*;

  logic                     be;
  logic                     v_q [DivSteps];
  div_t                     st_q [DivSteps];
  div_t                     st_d [DivSteps];
  step_t                    s0a, s0b;
  logic                     outside0;

  logic                     vm_q;
  status_e                  stm_q;
  status_e                  stm_d;
  logic [TW-1:0]            t0m_q, t1m_q, lo_lim, hi_lim;
  logic signed [CoordW-1:0] axm_q, aym_q;
  logic signed [PlaceW-1:0] prx_q, pry_q, sumx, sumy;

  logic                     vo_q;
  status_e                  sto_q;
  logic [TW-1:0]            t0o_q, t1o_q;
  logic signed [CoordW-1:0] cxo_q, cyo_q;

  assign be    = !(vo_q && out_stall_i);
  assign pop_o = be && !qstat_i.empty;

  always_comb begin
    outside0 = head_i.n0[WideW-1] || head_i.n1[WideW-1] ||
               (head_i.n0 > head_i.den) || (head_i.n1 > head_i.den);
    s0a = div_step(head_i.n0, head_i.den, '0, 1'b1);
    s0b = div_step(head_i.n1, head_i.den, '0, 1'b1);
    st_d[0].status = (head_i.status == ST_HIT && outside0) ? ST_OUTSIDE : head_i.status;
    st_d[0].d  = head_i.den;
    st_d[0].r0 = s0a.r;
    st_d[0].q0 = s0a.q;
    st_d[0].r1 = s0b.r;
    st_d[0].q1 = s0b.q;
    st_d[0].ax = head_i.ax;
    st_d[0].ay = head_i.ay;
    st_d[0].ux = head_i.ux;
    st_d[0].uy = head_i.uy;
    for (int k = 1; k < DivSteps; k++) begin
      st_d[k] = st_q[k-1];
      {st_d[k].r0, st_d[k].q0} = div_step(st_q[k-1].r0, st_q[k-1].d, st_q[k-1].q0, 1'b0);
      {st_d[k].r1, st_d[k].q1} = div_step(st_q[k-1].r1, st_q[k-1].d, st_q[k-1].q1, 1'b0);
    end
  end

  always_comb begin
    lo_lim = TW'(position_margin_i);
    hi_lim = OneQ24 - lo_lim;
    stm_d  = st_q[DivSteps-1].status;
    if (stm_d == ST_HIT &&
        (st_q[DivSteps-1].q0 < lo_lim || st_q[DivSteps-1].q0 > hi_lim ||
         st_q[DivSteps-1].q1 < lo_lim || st_q[DivSteps-1].q1 > hi_lim)) begin
      stm_d = ST_OUTSIDE;
    end
    sumx = prx_q + $signed(HalfQ24);
    sumy = pry_q + $signed(HalfQ24);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivSteps; k++) begin
        v_q[k] <= 1'b0;
      end
      vm_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (be) begin
      v_q[0] <= !qstat_i.empty;
      for (int k = 1; k < DivSteps; k++) begin
        v_q[k] <= v_q[k-1];
      end
      vm_q <= v_q[DivSteps-1];
      vo_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      for (int k = 0; k < DivSteps; k++) begin
        st_q[k] <= st_d[k];
      end
      stm_q <= stm_d;
      t0m_q <= st_q[DivSteps-1].q0;
      t1m_q <= st_q[DivSteps-1].q1;
      axm_q <= st_q[DivSteps-1].ax;
      aym_q <= st_q[DivSteps-1].ay;
      prx_q <= PlaceW'(st_q[DivSteps-1].ux * $signed({1'b0, st_q[DivSteps-1].q0}));
      pry_q <= PlaceW'(st_q[DivSteps-1].uy * $signed({1'b0, st_q[DivSteps-1].q0}));

      sto_q <= stm_q;
      if (stm_q == ST_HIT) begin
        t0o_q <= t0m_q;
        t1o_q <= t1m_q;
        cxo_q <= axm_q + $signed(sumx[TW-1+CoordW-1:TW-1]);
        cyo_q <= aym_q + $signed(sumy[TW-1+CoordW-1:TW-1]);
      end else begin
        t0o_q <= '0;
        t1o_q <= '0;
        cxo_q <= '0;
        cyo_q <= '0;
      end
    end
  end

  assign out_valid_o = vo_q;
  assign status_o    = sto_q;
  assign t_first_o   = t0o_q;
  assign t_second_o  = t1o_q;
  assign cross_x_o   = cxo_q;
  assign cross_y_o   = cyo_q;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && sto_q != ST_HIT) |-> (t0o_q == '0 && t1o_q == '0 && cxo_q == '0 && cyo_q == '0))
    else $error("miss result carries nonzero fields");

  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && sto_q == ST_HIT) |-> (t0o_q <= OneQ24 && t1o_q <= OneQ24))
    else $error("hit parameter above one");

  a_pop_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> v_q[0])
    else $error("popped request did not enter the divider");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vm_q && !be) |=> vm_q)
    else $error("request lost while back end stalled");

endmodule

>>> tb/sv/tb_segment_intersection_core.sv
`timescale 1ns / 100ps

module tb_segment_intersection_core;
  import segx_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 40;
  localparam logic [CfgIdxW-1:0] CfgUnused = CfgIdxW'(3);

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
  } seg_pair_t;

  typedef struct packed {
    status_e            status;
    logic [24:0]        t_first;
    logic [24:0]        t_second;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
  } crossing_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  seg_pair_t pair = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [24:0] t_first, t_second;
  logic signed [31:0] cross_x, cross_y;

  logic [15:0] zero_limit = 16'd1;
  logic [23:0] margin = 24'd17;

  seg_pair_t pending[$];
  crossing_t expected[$];
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int in_gap = 0;
  int out_wait = 0;
  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;
  int errors = 0;
  int cycles = 0;

  segment_intersection_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .first_start_x_i (pair.ax),
    .first_start_y_i (pair.ay),
    .first_end_x_i   (pair.bx),
    .first_end_y_i   (pair.by),
    .second_start_x_i(pair.cx),
    .second_start_y_i(pair.cy),
    .second_end_x_i  (pair.dx),
    .second_end_y_i  (pair.dy),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .t_first_o       (t_first),
    .t_second_o      (t_second),
    .cross_x_o       (cross_x),
    .cross_y_o       (cross_y)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit too_short(logic signed [127:0] ddx, logic signed [127:0] ddy);
    if (ddx <= -128'sd256 || ddx >= 128'sd256 || ddy <= -128'sd256 || ddy >= 128'sd256) begin
      return 1'b0;
    end
    return (ddx * ddx + ddy * ddy) < $signed({112'b0, zero_limit});
  endfunction

  function automatic crossing_t crossing_of(seg_pair_t p);
    logic signed [127:0] ax, ay, ux, uy, vx, vy, ey, ex;
    logic signed [127:0] den, n0, n1, t0, t1, lo, hi, off;
    crossing_t r;
    r = '0;
    ax = p.ax;
    ay = p.ay;
    ux = 128'(p.bx) - ax;
    uy = 128'(p.by) - ay;
    vx = 128'(p.dx) - 128'(p.cx);
    vy = 128'(p.dy) - 128'(p.cy);
    ey = 128'(p.cy) - ay;
    ex = ax - 128'(p.cx);
    if (too_short(ux, uy) || too_short(vx, vy)) begin
      r.status = ST_DEGEN;
      return r;
    end
    den = uy * vx - ux * vy;
    if (den == 0) begin
      r.status = ST_PARALLEL;
      return r;
    end
    n0 = vx * ey + vy * ex;
    n1 = ux * ey + uy * ex;
    if (den < 0) begin
      den = -den;
      n0 = -n0;
      n1 = -n1;
    end
    r.status = ST_OUTSIDE;
    if (n0 < 0 || n1 < 0 || n0 > den || n1 > den) return r;
    t0 = (n0 <<< 24) / den;
    t1 = (n1 <<< 24) / den;
    lo = $signed({104'b0, margin});
    hi = (128'sd1 <<< 24) - lo;
    if (t0 < lo || t0 > hi || t1 < lo || t1 > hi) return r;
    r.status = ST_HIT;
    r.t_first = t0[24:0];
    r.t_second = t1[24:0];
    off = (ux * t0 + (128'sd1 <<< 23)) >>> 24;
    r.cross_x = 32'(ax + off);
    off = (uy * t0 + (128'sd1 <<< 23)) >>> 24;
    r.cross_y = 32'(ay + off);
    return r;
  endfunction

  function automatic int span(int sc);
    return int'($urandom_range(0, 2 * sc)) - sc;
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int sc, k;
    real t, s, px, py;
    case ($urandom_range(0, 3))
      0: sc = 1024;
      1: sc = 65536;
      2: sc = 1 << 22;
      default: sc = 1 << 26;
    endcase
    p.ax = span(sc);
    p.ay = span(sc);
    p.bx = span(sc);
    p.by = span(sc);
    p.cx = span(sc);
    p.cy = span(sc);
    p.dx = span(sc);
    p.dy = span(sc);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        t = $urandom_range(1, 9999) / 10000.0;
        s = 1.02 + $urandom_range(0, 1400) / 1000.0;
        px = p.ax + t * (p.bx - p.ax);
        py = p.ay + t * (p.by - p.ay);
        p.dx = $rtoi(p.cx + s * (px - p.cx));
        p.dy = $rtoi(p.cy + s * (py - p.cy));
      end
      5: p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      6: begin
        k = $urandom_range(1, 3);
        if ($urandom_range(0, 1) == 1) begin
          p.cx = p.ax + (p.bx - p.ax) * ($urandom_range(0, 2) - 1);
          p.cy = p.ay + (p.by - p.ay) * ($urandom_range(0, 2) - 1);
        end
        p.dx = p.cx + (p.bx - p.ax) * k;
        p.dy = p.cy + (p.by - p.ay) * k;
      end
      7: begin
        p.bx = p.ax + span(20);
        p.by = p.ay + span(20);
      end
      8: begin
        p.dx = p.cx + span(300);
        p.dy = p.cy + span(300);
      end
      default: begin
        p.cx = p.ax;
        p.cy = p.ay;
      end
    endcase
    return p;
  endfunction

  function automatic seg_pair_t pair_of(int ax, int ay, int bx, int by,
                                         int cx, int cy, int dx, int dy);
    return {ax, ay, bx, by, cx, cy, dx, dy};
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    if (idx == CfgZeroLength) zero_limit = data[15:0];
    else if (idx == CfgMargin) margin = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic add_random(int count);
    repeat (count) pending.push_back(random_pair());
  endtask

  task automatic drain();
    while (pending.size() != 0 || in_valid || expected.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst_ni) begin
      if (in_valid && !in_taken) begin
      end else if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending.size() != 0) begin
        pair <= pending.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
        in_gap <= in_quiet ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid <= 1'b0;
      end
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
        out_wait = out_quiet ? 0 : $urandom_range(0, 3);
      end
      if (out_wait != 0) begin
        out_stall <= 1'b1;
        out_wait = out_wait - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    crossing_t want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    in_taken <= in_valid && !in_stall;
    out_taken <= out_valid && !out_stall;
    if (rst_ni && in_valid && !in_stall) expected.push_back(crossing_of(pair));
    if (rst_ni && out_valid && !out_stall) begin
      if (expected.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Result without a pending request: status %0d", status);
      end else begin
        want = expected.pop_front();
        if (status !== want.status || t_first !== want.t_first || t_second !== want.t_second
            || cross_x !== want.cross_x || cross_y !== want.cross_y) begin
          errors++;
          if (errors <= 10) begin
            $display("Mismatch: expected status %0d t0 %0d t1 %0d x %0d y %0d", want.status,
                     want.t_first, want.t_second, want.cross_x, want.cross_y);
            $display("          actual   status %0d t0 %0d t1 %0d x %0d y %0d", status,
                     t_first, t_second, cross_x, cross_y);
          end
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    pending.push_back(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(pair_of(0, 0, 256, 256, 0, 256, 256, 0));
    pending.push_back(pair_of(0, 0, 1, 0, 0, 5, 0, -5));
    pending.push_back(pair_of(0, 0, 255, 0, 100, 100, 100, -100));
    pending.push_back(pair_of(0, 0, 256, 0, 100, 100, 100, -100));
    pending.push_back(pair_of(0, 0, 1000, 0, 0, 10, 1000, 10));
    pending.push_back(pair_of(0, 0, 1000, 0, 500, 0, 1500, 0));
    pending.push_back(pair_of(0, 0, 1000, 0, 0, 10, 0, -10));
    pending.push_back(pair_of(0, 0, 1000, 0, 1000, 10, 1000, -10));
    pending.push_back(pair_of(0, 0, 1000, 0, 500, 0, 500, -10));
    pending.push_back(pair_of(0, 0, 1000, 0, 2000, 10, 2000, -10));
    pending.push_back(pair_of(0, 0, 1000, 0, 500, 10, 500, 5));
    pending.push_back(pair_of(int'(32'h80000000), int'(32'h80000000), 32'h7fffffff,
                              32'h7fffffff, int'(32'h80000000), 32'h7fffffff, 32'h7fffffff,
                              int'(32'h80000000)));
    pending.push_back(pair_of(32'h7fffffff, 32'h7fffffff, int'(32'h80000000),
                              int'(32'h80000000), 32'h7fffffff, int'(32'h80000000),
                              int'(32'h80000000), 32'h7fffffff));
    pending.push_back(pair_of(-1, -1, 1, 1, -1, 1, 1, -1));
    pending.push_back(pair_of(-1000, 3, 1000, 5, 7, -900, 9, 900));
    pending.push_back(pair_of(0, 0, 3, 7, 0, 0, 6, 14));
    pending.push_back(pair_of(5, 5, 5, 5, 0, 0, 100, 100));
    pending.push_back(pair_of(0, 0, 16777216, 1, 1, -16777216, 0, 16777216));
    pending.push_back(pair_of(-1, 0, 32'h7fffffff, 0, 0, -3, 0, 3));
    add_random(190);
    drain();

    write_reg(CfgZeroLength, 24'd0);
    write_reg(CfgMargin, 24'd0);
    pending.push_back(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(pair_of(0, 0, 1000, 0, 0, 10, 0, -10));
    pending.push_back(pair_of(0, 0, 1000, 0, 1000, 10, 1000, -10));
    add_random(170);
    drain();

    write_reg(CfgZeroLength, 24'hffffff);
    write_reg(CfgMargin, 24'd8388608);
    pending.push_back(pair_of(0, 0, 255, 255, 0, 255, 255, 0));
    pending.push_back(pair_of(0, 0, 1024, 1024, 0, 1024, 1024, 0));
    add_random(150);
    drain();

    write_reg(CfgZeroLength, 24'd300);
    write_reg(CfgMargin, 24'hffffff);
    write_reg(CfgUnused, 24'h000005);
    add_random(120);
    drain();

    write_reg(CfgZeroLength, 24'd2);
    write_reg(CfgMargin, 24'd8388609);
    add_random(60);
    drain();

    write_reg(CfgZeroLength, 24'd1);
    write_reg(CfgMargin, 24'd17);
    add_random(240);
    drain();

    if (errors == 0 && expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
